/* hdl/gtst_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtst_pkg
// shared constants, register codes and types of the segment tracker
// ----------------------------------------------------------------------------
package gtst_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int COORD_BITS_DEF = 18;

	localparam int REG_BITS       = 16;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [REG_BITS-1:0] GAP_LIMIT_RESET  = 16'd10;
	localparam logic [REG_BITS-1:0] MIN_LENGTH_RESET = 16'd30;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GAP_LIMIT  = 2'd0,
		REG_MIN_LENGTH = 2'd1
	} reg_index_t;

	// live register values handed to the tracker
	typedef struct packed {
		logic [REG_BITS-1:0] gap_limit;
		logic [REG_BITS-1:0] min_length;
	} cfg_t;

endpackage : gtst_pkg
`default_nettype wire

/* hdl/gtst_sample_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtst_sample_if
// valid/ready channel carrying one line sample per word
// ----------------------------------------------------------------------------
interface gtst_sample_if
	import gtst_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic                         edge_hit;
	logic                         line_end;

	modport source (
		output valid, point_x, point_y, edge_hit, line_end,
		input  ready
	);

	modport sink (
		input  valid, point_x, point_y, edge_hit, line_end,
		output ready
	);
endinterface : gtst_sample_if
`default_nettype wire

/* hdl/gtst_segment_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtst_segment_if
// valid/ready channel carrying one finished segment per word
// ----------------------------------------------------------------------------
interface gtst_segment_if
	import gtst_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source (
		output valid, start_x, start_y, end_x, end_y,
		input  ready
	);

	modport sink (
		input  valid, start_x, start_y, end_x, end_y,
		output ready
	);
endinterface : gtst_segment_if
`default_nettype wire

/* hdl/gtst_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtst_cfg_regs
// gap limit and minimum length registers behind the plain write port
// ----------------------------------------------------------------------------
module gtst_cfg_regs
	import gtst_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [REG_BITS-1:0]       cfg_data,
	output cfg_t                           cfg
);
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_limit  <= GAP_LIMIT_RESET;
			cfg_q.min_length <= MIN_LENGTH_RESET;
		end else if (cfg_we) begin
			// unknown indexes are dropped
			unique case (cfg_index)
				REG_GAP_LIMIT:  cfg_q.gap_limit  <= cfg_data;
				REG_MIN_LENGTH: cfg_q.min_length <= cfg_data;
				default:        ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule : gtst_cfg_regs
`default_nettype wire

/* hdl/gtst_track.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtst_track
// open-segment state and its per-sample update, with the close decision
// ----------------------------------------------------------------------------
module gtst_track
	import gtst_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire logic                         hit,
	input  wire logic                         last,
	input  wire logic signed [COORD_BITS-1:0] px,
	input  wire logic signed [COORD_BITS-1:0] py,
	input  wire cfg_t                         cfg,
	output logic                              emit,
	output logic signed [COORD_BITS-1:0]      start_x,
	output logic signed [COORD_BITS-1:0]      start_y,
	output logic signed [COORD_BITS-1:0]      end_x,
	output logic signed [COORD_BITS-1:0]      end_y
);
	localparam int CMP_BITS = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;

	logic                         open_q;
	logic [COUNT_BITS-1:0]        hit_cnt_q;
	logic [COUNT_BITS-1:0]        miss_cnt_q;
	logic signed [COORD_BITS-1:0] first_x_q;
	logic signed [COORD_BITS-1:0] first_y_q;
	logic signed [COORD_BITS-1:0] latest_x_q;
	logic signed [COORD_BITS-1:0] latest_y_q;

	logic                         open_d;
	logic [COUNT_BITS-1:0]        hit_cnt_d;
	logic [COUNT_BITS-1:0]        miss_cnt_d;
	logic signed [COORD_BITS-1:0] first_x_d;
	logic signed [COORD_BITS-1:0] first_y_d;
	logic signed [COORD_BITS-1:0] latest_x_d;
	logic signed [COORD_BITS-1:0] latest_y_d;

	logic [COUNT_BITS-1:0]        hit_base;
	logic [COUNT_BITS-1:0]        miss_inc;
	logic                         gap_close;
	logic                         end_close;
	logic                         long_enough;

	always_comb begin
		open_d     = open_q;
		hit_cnt_d  = hit_cnt_q;
		miss_cnt_d = miss_cnt_q;
		first_x_d  = first_x_q;
		first_y_d  = first_y_q;
		latest_x_d = latest_x_q;
		latest_y_d = latest_y_q;
		gap_close  = 1'b0;

		hit_base = open_q ? hit_cnt_q : '0;
		miss_inc = (&miss_cnt_q) ? miss_cnt_q : miss_cnt_q + 1'b1;

		if (hit) begin
			open_d = 1'b1;
			if (!open_q) begin
				first_x_d = px;
				first_y_d = py;
			end
			hit_cnt_d  = (&hit_base) ? hit_base : hit_base + 1'b1;
			miss_cnt_d = '0;
			latest_x_d = px;
			latest_y_d = py;
		end else if (open_q) begin
			miss_cnt_d = miss_inc;
			gap_close  = CMP_BITS'(miss_inc) > CMP_BITS'(cfg.gap_limit);
		end

		// gap close and line end never both fire: end_close is masked by gap_close
		end_close   = last && open_d && !gap_close;
		long_enough = CMP_BITS'(hit_cnt_d) >= CMP_BITS'(cfg.min_length);
		emit        = (gap_close || end_close) && long_enough;

		if (gap_close || last) begin
			open_d     = 1'b0;
			hit_cnt_d  = '0;
			miss_cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (advance) begin
			open_q     <= open_d;
			hit_cnt_q  <= hit_cnt_d;
			miss_cnt_q <= miss_cnt_d;
		end
	end

	// coordinates are only read while a segment is open
	always_ff @(posedge clk) begin
		if (advance) begin
			first_x_q  <= first_x_d;
			first_y_q  <= first_y_d;
			latest_x_q <= latest_x_d;
			latest_y_q <= latest_y_d;
		end
	end

	assign start_x = first_x_d;
	assign start_y = first_y_d;
	assign end_x   = latest_x_d;
	assign end_y   = latest_y_d;

endmodule : gtst_track
`default_nettype wire

/* hdl/gap_tolerant_segment_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gap_tolerant_segment_tracker
// finds edge segments along one scanned line, bridging short gaps
// ----------------------------------------------------------------------------
// Samples along a candidate line come in one word per cycle; each word holds
// a Q13.4 point and an edge-hit flag (bounds test already applied). The block
// keeps one open segment and closes it once more than gap_limit misses in a
// row follow its last hit, or at the word flagged line_end. A closed segment
// with at least min_length hits leaves as one word carrying its first and
// last hit points; line_end also clears the tracker for the next line. Hit
// and miss counts saturate. Throughput is one sample per cycle while no
// finished segment waits unread: the whole state update of a sample is
// combinational logic between the input register and the result register,
// which holds its segment word. The output register lets the next sample
// enter while a finished segment still waits; only a sample that arrives
// while the result register is full and unread is held back. Configuration
// writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module gap_tolerant_segment_tracker
	import gtst_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// register write port
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [REG_BITS-1:0]       cfg_data,
	// sample words in, segment words out
	gtst_sample_if.sink                    samples,
	gtst_segment_if.source                 segments
);
	cfg_t cfg;

	// input register
	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] px_s1;
	logic signed [COORD_BITS-1:0] py_s1;
	logic                         hit_s1;
	logic                         last_s1;

	// result register
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] start_x_q;
	logic signed [COORD_BITS-1:0] start_y_q;
	logic signed [COORD_BITS-1:0] end_x_q;
	logic signed [COORD_BITS-1:0] end_y_q;

	logic                         advance;
	logic                         emit;
	logic signed [COORD_BITS-1:0] seg_start_x;
	logic signed [COORD_BITS-1:0] seg_start_y;
	logic signed [COORD_BITS-1:0] seg_end_x;
	logic signed [COORD_BITS-1:0] seg_end_y;

	gtst_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the sample in the input register is processed once the result
	// register is free or is being read in this cycle
	assign advance       = valid_s1 && (!out_valid_q || segments.ready);
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			px_s1   <= samples.point_x;
			py_s1   <= samples.point_y;
			hit_s1  <= samples.edge_hit;
			last_s1 <= samples.line_end;
		end
	end

	gtst_track #(
		.COUNT_BITS (COUNT_BITS),
		.COORD_BITS (COORD_BITS)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.hit     (hit_s1),
		.last    (last_s1),
		.px      (px_s1),
		.py      (py_s1),
		.cfg     (cfg),
		.emit    (emit),
		.start_x (seg_start_x),
		.start_y (seg_start_y),
		.end_x   (seg_end_x),
		.end_y   (seg_end_y)
	);

	// result word: loaded when a processed sample closes a long segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (segments.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			start_x_q <= seg_start_x;
			start_y_q <= seg_start_y;
			end_x_q   <= seg_end_x;
			end_y_q   <= seg_end_y;
		end
	end

	assign segments.valid   = out_valid_q;
	assign segments.start_x = start_x_q;
	assign segments.start_y = start_y_q;
	assign segments.end_x   = end_x_q;
	assign segments.end_y   = end_y_q;

endmodule : gap_tolerant_segment_tracker
`default_nettype wire
